FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define SME_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define SME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define SME_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SME_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

FILE: sv/sme_pkg.sv
package sme_pkg;

    localparam int DATA_W          = 32;
    localparam int OP_W            = 3;
    localparam int IMM_W           = 8;
    localparam int ST_W            = 3;
    localparam int DEPTH_W         = 7;
    localparam int STACK_DEPTH_DEF = 64;

    typedef logic [OP_W-1:0] t_op;

    localparam t_op OP_PUSH = 3'd0;
    localparam t_op OP_ADD  = 3'd1;
    localparam t_op OP_SUB  = 3'd2;
    localparam t_op OP_MUL  = 3'd3;
    localparam t_op OP_DIV  = 3'd4;
    localparam t_op OP_HALT = 3'd5;

    typedef enum logic [ST_W-1:0] {
        ST_OK    = 3'd0,
        ST_HALT  = 3'd1,
        ST_BADOP = 3'd2,
        ST_STACK = 3'd3,
        ST_DIVZ  = 3'd4
    } t_status;

endpackage

FILE: sv/sme_instr_if.sv
interface sme_instr_if import sme_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [IMM_W-1:0] imm;

    modport source (output valid, output op, output imm, input ready);
    modport sink   (input valid, input op, input imm, output ready);
endinterface

FILE: sv/sme_result_if.sv
interface sme_result_if import sme_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [ST_W-1:0]          status;
    logic [DEPTH_W-1:0]       depth;
    logic signed [DATA_W-1:0] top_value;

    modport source (output valid, output status, output depth, output top_value, input ready);
    modport sink   (input valid, input status, input depth, input top_value, output ready);
endinterface

FILE: sv/sme_div.sv
module sme_div import sme_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quotient
);

    localparam int STEP_W = $clog2(DATA_W + 1);

    logic [DATA_W:0]     r_rem;
    logic [DATA_W-1:0]   r_quo;
    logic [DATA_W-1:0]   r_div;
    logic                r_neg;
    logic                r_busy;
    logic                r_done;
    logic [STEP_W-1:0]   r_cnt;

    logic [DATA_W:0]     w_shift;
    logic [DATA_W:0]     w_diff;
    logic                w_ge;

    assign w_shift = {r_rem[DATA_W-1:0], r_quo[DATA_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = !w_diff[DATA_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= STEP_W'(DATA_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend[DATA_W-1] ? (DATA_W'(0) - i_dividend) : i_dividend;
            r_div <= i_divisor[DATA_W-1] ? (DATA_W'(0) - i_divisor) : i_divisor;
            r_neg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff : w_shift;
            r_quo <= {r_quo[DATA_W-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_neg ? (DATA_W'(0) - r_quo) : r_quo;

endmodule

FILE: sv/stack_machine_executor.sv
// Channel   Dir  Interface      Payload
// i_instr   in   sme_instr_if   op[2:0], imm[7:0]
// o_result  out  sme_result_if  status[2:0], depth[6:0], top_value[31:0] signed
//
// Push, halt, unknown opcodes and stack errors: result is registered straight from the idle state.
// Add, sub, divide by zero: S_EX after the stack memory read; mul adds S_MUL (product register).
// Div: S_EX then S_DIV, using the bit-serial divider (one quotient bit per cycle).
// One instruction in flight; a result waiting in the output register stalls the next one.
// Synchronous active-low reset empties the stack; stack memory contents are not cleared.
`include "assert_macros.svh"

module stack_machine_executor import sme_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    sme_instr_if.sink    i_instr,
    sme_result_if.source o_result
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EX   = 4'b0010,
        S_MUL  = 4'b0100,
        S_DIV  = 4'b1000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [DATA_W-1:0]   r_top, n_top;
    t_op                 r_op, n_op;
    logic [DATA_W-1:0]   r_prod, n_prod;
    logic                r_ovalid, n_ovalid;
    t_status             r_ostatus, n_ostatus;
    logic [DEPTH_W-1:0]  r_odepth, n_odepth;
    logic [DATA_W-1:0]   r_otop, n_otop;

    logic [DATA_W-1:0]   r_stack [STACK_DEPTH];
    logic [DATA_W-1:0]   r_rdata;

    logic                w_in_fire;
    logic                w_oslot;
    logic                w_we;
    logic [IDX_W-1:0]    w_widx;
    logic [IDX_W-1:0]    w_ridx;
    logic [DATA_W-1:0]   w_cur_top;
    logic [DATA_W-1:0]   w_prod;
    logic                w_commit;
    logic [DATA_W-1:0]   w_res;
    logic                w_div_start;
    logic                w_div_done;
    logic [DATA_W-1:0]   w_div_q;

    assign w_oslot   = !r_ovalid || o_result.ready;
    assign w_in_fire = i_instr.valid && i_instr.ready;
    assign w_widx    = IDX_W'(r_count - CNT_W'(1));
    assign w_ridx    = IDX_W'(r_count - CNT_W'(2));
    assign w_cur_top = (r_count == '0) ? '0 : r_top;
    assign w_prod    = DATA_W'(r_rdata * r_top);

    assign i_instr.ready      = (r_state == S_IDLE) && w_oslot;
    assign o_result.valid     = r_ovalid;
    assign o_result.status    = r_ostatus;
    assign o_result.depth     = r_odepth;
    assign o_result.top_value = $signed(r_otop);

    sme_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_rdata),
        .i_divisor  (r_top),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_stack[w_widx] <= r_top;
        end
        r_rdata <= r_stack[w_ridx];
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_top       = r_top;
        n_op        = r_op;
        n_prod      = r_prod;
        n_ovalid    = r_ovalid && !o_result.ready;
        n_ostatus   = r_ostatus;
        n_odepth    = r_odepth;
        n_otop      = r_otop;
        w_we        = 1'b0;
        w_commit    = 1'b0;
        w_res       = r_prod;
        w_div_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    n_op     = i_instr.op;
                    n_ovalid = 1'b1;
                    n_odepth = DEPTH_W'(r_count);
                    n_otop   = w_cur_top;
                    if (i_instr.op == OP_PUSH) begin
                        if (r_count >= CNT_W'(STACK_DEPTH)) begin
                            n_ostatus = ST_STACK;
                        end else begin
                            w_we      = (r_count != '0);
                            n_top     = DATA_W'(i_instr.imm);
                            n_count   = r_count + CNT_W'(1);
                            n_ostatus = ST_OK;
                            n_odepth  = DEPTH_W'(r_count + CNT_W'(1));
                            n_otop    = DATA_W'(i_instr.imm);
                        end
                    end else if (i_instr.op inside {OP_ADD, OP_SUB, OP_MUL, OP_DIV}) begin
                        if (r_count < CNT_W'(2)) begin
                            n_ostatus = ST_STACK;
                        end else begin
                            n_ovalid = r_ovalid && !o_result.ready;
                            n_state  = S_EX;
                        end
                    end else if (i_instr.op == OP_HALT) begin
                        n_ostatus = ST_HALT;
                    end else begin
                        n_ostatus = ST_BADOP;
                    end
                end
            end
            S_EX: begin
                case (r_op)
                    OP_ADD: begin
                        w_res    = r_rdata + r_top;
                        w_commit = w_oslot;
                    end
                    OP_SUB: begin
                        w_res    = r_rdata - r_top;
                        w_commit = w_oslot;
                    end
                    OP_MUL: begin
                        n_prod  = w_prod;
                        n_state = S_MUL;
                    end
                    default: begin
                        if (r_top == '0) begin
                            if (w_oslot) begin
                                n_ovalid  = 1'b1;
                                n_ostatus = ST_DIVZ;
                                n_odepth  = DEPTH_W'(r_count);
                                n_otop    = r_top;
                                n_state   = S_IDLE;
                            end
                        end else begin
                            w_div_start = 1'b1;
                            n_state     = S_DIV;
                        end
                    end
                endcase
            end
            S_MUL: begin
                w_res    = r_prod;
                w_commit = w_oslot;
            end
            S_DIV: begin
                w_res    = w_div_q;
                w_commit = w_div_done && w_oslot;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_commit) begin
            n_top     = w_res;
            n_count   = r_count - CNT_W'(1);
            n_ovalid  = 1'b1;
            n_ostatus = ST_OK;
            n_odepth  = DEPTH_W'(r_count - CNT_W'(1));
            n_otop    = w_res;
            n_state   = S_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top     <= n_top;
        r_op      <= n_op;
        r_prod    <= n_prod;
        r_ostatus <= n_ostatus;
        r_odepth  <= n_odepth;
        r_otop    <= n_otop;
    end

    `SME_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(STACK_DEPTH))
    `SME_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n,
        w_in_fire && i_instr.op == OP_PUSH && r_count < CNT_W'(STACK_DEPTH),
        r_count == $past(r_count) + CNT_W'(1))
    `SME_ASSERT_NEXT(a_commit_pops, i_clk, i_rst_n, w_commit,
        r_count == $past(r_count) - CNT_W'(1) && r_state == S_IDLE)
    `SME_ASSERT_IMPL(a_div_in_state, i_clk, i_rst_n, $rose(w_div_done), r_state == S_DIV)

endmodule
